>>> src/utlc_pkg.sv
// ============================================================================
// utlc_pkg
// Shared constants, reciprocal multipliers and types for the Unix time to
// local calendar converter.
// ============================================================================
`default_nettype none

package utlc_pkg;

  // Pipeline depth, from the input register to the output register.
  localparam int NUM_STAGES = 11;

  // All constant divisions use a ceiling reciprocal scaled by 2^RECIP_SHIFT.
  // For dividends and divisors below 2^18 (and the day split's 26-bit
  // dividend against 675) the truncated product equals the exact quotient.
  localparam int RECIP_SHIFT = 36;

  localparam logic [63:0] RECIP_675   = ((64'd1 << RECIP_SHIFT) + 64'd674) / 64'd675;
  localparam logic [63:0] RECIP_1460  = ((64'd1 << RECIP_SHIFT) + 64'd1459) / 64'd1460;
  localparam logic [63:0] RECIP_36524 = ((64'd1 << RECIP_SHIFT) + 64'd36523) / 64'd36524;
  localparam logic [63:0] RECIP_365   = ((64'd1 << RECIP_SHIFT) + 64'd364) / 64'd365;
  localparam logic [63:0] RECIP_100   = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
  localparam logic [63:0] RECIP_153   = ((64'd1 << RECIP_SHIFT) + 64'd152) / 64'd153;
  localparam logic [63:0] RECIP_3600  = ((64'd1 << RECIP_SHIFT) + 64'd3599) / 64'd3600;
  localparam logic [63:0] RECIP_60    = ((64'd1 << RECIP_SHIFT) + 64'd59) / 64'd60;

  localparam int RECIP_675_W   = $clog2(RECIP_675 + 64'd1);
  localparam int RECIP_1460_W  = $clog2(RECIP_1460 + 64'd1);
  localparam int RECIP_36524_W = $clog2(RECIP_36524 + 64'd1);
  localparam int RECIP_365_W   = $clog2(RECIP_365 + 64'd1);
  localparam int RECIP_100_W   = $clog2(RECIP_100 + 64'd1);
  localparam int RECIP_153_W   = $clog2(RECIP_153 + 64'd1);
  localparam int RECIP_3600_W  = $clog2(RECIP_3600 + 64'd1);
  localparam int RECIP_60_W    = $clog2(RECIP_60 + 64'd1);

  // Local offset register reset value: UTC minus four hours.
  localparam logic signed [16:0] OFFSET_RESET = -17'sd14400;

  // One day of bias keeps the local second count positive; the day count
  // that comes out is then one above the floor-divided day number.
  localparam logic [32:0] DAY_BIAS = 33'd86400;

  // Shift from 1970-01-01 to 0000-03-01, less the one day of bias above.
  localparam logic [19:0] MARCH0_BIAS = 20'd719467;

  localparam int          DAYS_PER_ERA = 146097;
  localparam logic [19:0] ERA4_BASE    = 20'(4 * DAYS_PER_ERA);
  localparam logic [19:0] ERA5_BASE    = 20'(5 * DAYS_PER_ERA);
  localparam logic [17:0] LAST_DOE     = 18'd146096;

  localparam logic [10:0] ERA4_YEAR = 11'd1600;
  localparam logic [10:0] ERA5_YEAR = 11'd2000;

  // Result beat, first field in the highest bits.
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } cal_result_t;

  // First day of a March-based month within the year: (153 * mp + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start;
    unique case (mp)
      4'd0:    start = 9'd0;
      4'd1:    start = 9'd31;
      4'd2:    start = 9'd61;
      4'd3:    start = 9'd92;
      4'd4:    start = 9'd122;
      4'd5:    start = 9'd153;
      4'd6:    start = 9'd184;
      4'd7:    start = 9'd214;
      4'd8:    start = 9'd245;
      4'd9:    start = 9'd275;
      4'd10:   start = 9'd306;
      4'd11:   start = 9'd337;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

`default_nettype wire

>>> src/unix_time_to_local_calendar.sv
// ============================================================================
// unix_time_to_local_calendar
// Unix time to local proleptic Gregorian date and time of day.
// ============================================================================
// Each input beat carries an unsigned 32-bit Unix time; the block adds the
// signed local offset register (reset: UTC minus four hours) and returns one
// beat with year, month, day, hour, minute and second. The pipeline has 11
// register stages and takes a new beat every cycle unless back-pressure from
// the output stalls it, so throughput is one beat per cycle; the depth comes
// from the chain of constant divisions (by 86400, 1460, 36524, 365, 100,
// 153, 3600 and 60), each done as a reciprocal multiply. A stage takes a new
// beat whenever it is empty or the next stage moves, so bubbles close up under
// back-pressure. The configuration channel is always ready; write it only
// while no beats are in flight.
// ============================================================================
`default_nettype none

module unix_time_to_local_calendar (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] unix_seconds

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [39:0] m_axis_tdata,   // [11:0] year, [15:12] month,
                                           // [20:16] day, [25:21] hour,
                                           // [31:26] minute, [37:32] second,
                                           // [39:38] zero

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [16:0] cfg_data        // [16:0] local_offset_seconds
);

  localparam int N = utlc_pkg::NUM_STAGES;

  logic signed [16:0]    offset;
  logic [N-1:0]          vld;
  logic [N-1:0]          en;
  logic [15:0]           days_biased;
  logic [16:0]           sod;
  utlc_pkg::cal_result_t result;

  // Offset register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= utlc_pkg::OFFSET_RESET;
    end else if (cfg_valid) begin
      offset <= cfg_data;
    end
  end

  // Stage load enables: a stage loads when it is empty or its beat moves on.
  assign en[N-1] = !vld[N-1] || m_axis_tready;
  for (genvar i = 0; i < N - 1; i++) begin : g_en
    assign en[i] = !vld[i] || en[i+1];
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (en[i]) begin
          vld[i] <= (i == 0) ? s_axis_tvalid : vld[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[N-1];

  // Offset add and day split, stages 0 to 2.
  utlc_day_split u_day_split (
    .clk          (clk),
    .en           (en[2:0]),
    .unix_seconds (s_axis_tdata),
    .offset       (offset),
    .days_biased  (days_biased),
    .sod          (sod)
  );

  // Date from day count, stages 3 to 10.
  utlc_civil_date u_civil_date (
    .clk         (clk),
    .en          (en[10:3]),
    .days_biased (days_biased),
    .year        (result.year),
    .month       (result.month),
    .day         (result.day)
  );

  // Time of day, stages 3 to 10.
  utlc_clock_split u_clock_split (
    .clk    (clk),
    .en     (en[10:3]),
    .sod    (sod),
    .hour   (result.hour),
    .minute (result.minute),
    .second (result.second)
  );

  assign m_axis_tdata = {2'b00, result};

  // A ready sink must never back up to the input side.
  a_ready_through: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while the output sink is ready");

  // An accepted beat occupies the first stage.
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vld[0])
    else $error("accepted beat lost at the first stage");

  a_month: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> result.month >= 4'd1 && result.month <= 4'd12)
    else $error("month out of range");

  a_day_hour: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> result.day >= 5'd1 && result.hour <= 5'd23)
    else $error("day or hour out of range");

  a_min_sec: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> result.minute <= 6'd59 && result.second <= 6'd59)
    else $error("minute or second out of range");

endmodule

`default_nettype wire

>>> src/utlc_day_split.sv
// ============================================================================
// utlc_day_split
// Adds the local offset and splits local seconds into a biased day count and
// seconds of day, over three pipeline stages.
// ============================================================================
`default_nettype none

module utlc_day_split (
  input  wire logic               clk,
  input  wire logic [2:0]         en,
  input  wire logic [31:0]        unix_seconds,
  input  wire logic signed [16:0] offset,
  output logic      [15:0]        days_biased,
  output logic      [16:0]        sod
);

  localparam int PROD_W = 26 + utlc_pkg::RECIP_675_W;

  logic [32:0]       local_sec;
  logic [PROD_W-1:0] quot_prod;
  logic [25:0]       hi_part;
  logic [6:0]        lo_part;

  logic [15:0] quot;
  logic [25:0] quot_x675;
  logic [25:0] rem_hi;

  // Stage 0: local seconds plus one day of bias, always positive.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      local_sec <= {1'b0, unix_seconds} + {{16{offset[16]}}, offset} + utlc_pkg::DAY_BIAS;
    end
  end

  // Stage 1: 86400 = 128 * 675; divide the upper part by 675 with a reciprocal.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      quot_prod <= local_sec[32:7] * utlc_pkg::RECIP_675[utlc_pkg::RECIP_675_W-1:0];
      hi_part   <= local_sec[32:7];
      lo_part   <= local_sec[6:0];
    end
  end

  // Stage 2: quotient is the day count, remainder rebuilds seconds of day.
  assign quot      = quot_prod[utlc_pkg::RECIP_SHIFT +: 16];
  assign quot_x675 = {10'd0, quot} * 26'd675;
  assign rem_hi    = hi_part - quot_x675;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      days_biased <= quot;
      sod         <= {rem_hi[9:0], lo_part};
    end
  end

endmodule

`default_nettype wire

>>> src/utlc_civil_date.sv
// ============================================================================
// utlc_civil_date
// Converts a biased day count into year, month and day by the 400-year era
// method, over eight pipeline stages.
// ============================================================================
`default_nettype none

module utlc_civil_date (
  input  wire logic        clk,
  input  wire logic [7:0]  en,
  input  wire logic [15:0] days_biased,
  output logic      [11:0] year,
  output logic      [3:0]  month,
  output logic      [4:0]  day
);

  localparam int P1460_W  = 18 + utlc_pkg::RECIP_1460_W;
  localparam int P36524_W = 18 + utlc_pkg::RECIP_36524_W;
  localparam int P365_W   = 18 + utlc_pkg::RECIP_365_W;
  localparam int P100_W   = 9 + utlc_pkg::RECIP_100_W;
  localparam int P153_W   = 11 + utlc_pkg::RECIP_153_W;

  // Stage 3 signals.
  logic [19:0] z;
  logic        z_era5;
  logic [19:0] z_doe;
  logic [17:0] doe3;
  logic        era3;

  // Stage 4 signals.
  logic [P1460_W-1:0]  p1460;
  logic [P36524_W-1:0] p36524;
  logic [7:0]          n1460;
  logic [2:0]          n36524;
  logic                last4;
  logic [17:0]         doe4;
  logic                era4;

  // Stage 5 signals.
  logic [17:0] ynum5;
  logic [17:0] doe5;
  logic        era5;

  // Stage 6 signals.
  logic [P365_W-1:0] p365;
  logic [8:0]        yoe6;
  logic [17:0]       doe6;
  logic              era6;

  // Stage 7 signals.
  logic [P100_W-1:0] p100;
  logic [17:0]       t1_7;
  logic [1:0]        c100_7;
  logic [8:0]        yoe7;
  logic [17:0]       doe7;
  logic              era7;

  // Stage 8 signals.
  logic [17:0] doy_full;
  logic [8:0]  doy8;
  logic [8:0]  yoe8;
  logic        era8;

  // Stage 9 signals.
  logic [10:0]       num153;
  logic [P153_W-1:0] p153;
  logic [3:0]        mp9;
  logic [8:0]        doy9;
  logic [8:0]        yoe9;
  logic              era9;

  // Stage 10 signals.
  logic [3:0]  mon;
  logic [8:0]  dom;
  logic [11:0] yr;

  // Stage 3: shift to a March-based day number and pick the era.
  assign z      = {4'd0, days_biased} + utlc_pkg::MARCH0_BIAS;
  assign z_era5 = (z >= utlc_pkg::ERA5_BASE);
  assign z_doe  = z_era5 ? (z - utlc_pkg::ERA5_BASE) : (z - utlc_pkg::ERA4_BASE);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      doe3 <= z_doe[17:0];
      era3 <= z_era5;
    end
  end

  // Stage 4: leap-cycle corrections of the day of era.
  assign p1460  = doe3 * utlc_pkg::RECIP_1460[utlc_pkg::RECIP_1460_W-1:0];
  assign p36524 = doe3 * utlc_pkg::RECIP_36524[utlc_pkg::RECIP_36524_W-1:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n1460  <= p1460[utlc_pkg::RECIP_SHIFT +: 8];
      n36524 <= p36524[utlc_pkg::RECIP_SHIFT +: 3];
      last4  <= (doe3 == utlc_pkg::LAST_DOE);
      doe4   <= doe3;
      era4   <= era3;
    end
  end

  // Stage 5: day of era with leap days removed.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      ynum5 <= doe4 - {10'd0, n1460} + {15'd0, n36524} - {17'd0, last4};
      doe5  <= doe4;
      era5  <= era4;
    end
  end

  // Stage 6: year of era.
  assign p365 = ynum5 * utlc_pkg::RECIP_365[utlc_pkg::RECIP_365_W-1:0];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      yoe6 <= p365[utlc_pkg::RECIP_SHIFT +: 9];
      doe6 <= doe5;
      era6 <= era5;
    end
  end

  // Stage 7: days before this year within the era, in two parts.
  assign p100 = yoe6 * utlc_pkg::RECIP_100[utlc_pkg::RECIP_100_W-1:0];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t1_7   <= ({9'd0, yoe6} * 18'd365) + {11'd0, yoe6[8:2]};
      c100_7 <= p100[utlc_pkg::RECIP_SHIFT +: 2];
      yoe7   <= yoe6;
      doe7   <= doe6;
      era7   <= era6;
    end
  end

  // Stage 8: day of the March-based year.
  assign doy_full = doe7 - t1_7 + {16'd0, c100_7};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      doy8 <= doy_full[8:0];
      yoe8 <= yoe7;
      era8 <= era7;
    end
  end

  // Stage 9: March-based month index.
  assign num153 = {doy8, 2'b00} + {2'b00, doy8} + 11'd2;
  assign p153   = num153 * utlc_pkg::RECIP_153[utlc_pkg::RECIP_153_W-1:0];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mp9  <= p153[utlc_pkg::RECIP_SHIFT +: 4];
      doy9 <= doy8;
      yoe9 <= yoe8;
      era9 <= era8;
    end
  end

  // Stage 10: calendar month, day of month and year; January and February
  // belong to the following calendar year.
  assign mon = (mp9 < 4'd10) ? (mp9 + 4'd3) : (mp9 - 4'd9);
  assign dom = doy9 - utlc_pkg::month_start(mp9) + 9'd1;
  assign yr  = {3'd0, yoe9}
             + {1'b0, (era9 ? utlc_pkg::ERA5_YEAR : utlc_pkg::ERA4_YEAR)}
             + {11'd0, (mon <= 4'd2)};

  always_ff @(posedge clk) begin
    if (en[7]) begin
      month <= mon;
      day   <= dom[4:0];
      year  <= yr;
    end
  end

endmodule

`default_nettype wire

>>> src/utlc_clock_split.sv
// ============================================================================
// utlc_clock_split
// Splits seconds of day into hour, minute and second, delayed to line up with
// the date pipeline.
// ============================================================================
`default_nettype none

module utlc_clock_split (
  input  wire logic        clk,
  input  wire logic [7:0]  en,
  input  wire logic [16:0] sod,
  output logic      [4:0]  hour,
  output logic      [5:0]  minute,
  output logic      [5:0]  second
);

  localparam int P3600_W = 17 + utlc_pkg::RECIP_3600_W;
  localparam int P60_W   = 12 + utlc_pkg::RECIP_60_W;
  localparam int DELAY   = 4;

  logic [P3600_W-1:0] p3600;
  logic [4:0]         hour3;
  logic [16:0]        sod3;

  logic [16:0] h3600;
  logic [16:0] rem_full;
  logic [4:0]  hour4;
  logic [11:0] rem4;

  logic [P60_W-1:0] p60;
  logic [4:0]       hour5;
  logic [5:0]       min5;
  logic [11:0]      rem5;

  logic [11:0] m60;
  logic [11:0] sec_full;
  logic [16:0] hms6;

  logic [16:0] hms_dly [DELAY];

  // Stage 3: hour.
  assign p3600 = sod * utlc_pkg::RECIP_3600[utlc_pkg::RECIP_3600_W-1:0];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hour3 <= p3600[utlc_pkg::RECIP_SHIFT +: 5];
      sod3  <= sod;
    end
  end

  // Stage 4: seconds within the hour.
  assign h3600    = {12'd0, hour3} * 17'd3600;
  assign rem_full = sod3 - h3600;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hour4 <= hour3;
      rem4  <= rem_full[11:0];
    end
  end

  // Stage 5: minute.
  assign p60 = rem4 * utlc_pkg::RECIP_60[utlc_pkg::RECIP_60_W-1:0];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      hour5 <= hour4;
      min5  <= p60[utlc_pkg::RECIP_SHIFT +: 6];
      rem5  <= rem4;
    end
  end

  // Stage 6: second.
  assign m60      = {6'd0, min5} * 12'd60;
  assign sec_full = rem5 - m60;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      hms6 <= {hour5, min5, sec_full[5:0]};
    end
  end

  // Stages 7 to 10: delay line matching the date pipeline.
  for (genvar k = 0; k < DELAY; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en[4 + k]) begin
        hms_dly[k] <= (k == 0) ? hms6 : hms_dly[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign hour   = hms_dly[DELAY-1][16:12];
  assign minute = hms_dly[DELAY-1][11:6];
  assign second = hms_dly[DELAY-1][5:0];

endmodule

`default_nettype wire
